[design/shortest_remaining_time_scheduler_defines.svh]
// Assertion macros for the shortest-remaining-time scheduler.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define SRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/srt_pkg.sv]
// Shared types and constants for the shortest-remaining-time scheduler.
// No dependencies.
package srt_pkg;

	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int TIME_W   = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		STS_CLEARED = 3'd0,
		STS_ADDED   = 3'd1,
		STS_FULL    = 3'd2,
		STS_IDLE    = 3'd3,
		STS_RAN     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              started;
		logic [TIME_W-1:0] ready;
		logic [TIME_W-1:0] rem;
	} job_entry_t;

endpackage

[design/shortest_remaining_time_scheduler.sv]
// Shortest-remaining-time scheduler: job table in one synchronous RAM, scan FSM.
// Depends on srt_pkg and shortest_remaining_time_scheduler_defines.svh.
//
// Words on the request channel are clear, add or tick; each gives one response word
// (an unused opcode is taken and gives none). Clear and add pass through the result
// state back to idle. A tick reads the job table one entry per cycle from the
// single RAM read port: it scans job_count entries, drains the read, updates the
// picked entry, loads the response and returns to idle; with an empty table it skips
// the scan and drain. The response is loaded only once the response register is free.
// One request is worked at a time; a new request is taken while the previous response
// still waits on the response channel.
module shortest_remaining_time_scheduler
	import srt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        opcode,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [TIME_W-1:0] burst_length,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [2:0]        status,
	output logic [7:0]        job_index,
	output logic              first_run,
	output logic              finished,
	output logic [TIME_W-1:0] first_wait,
	output logic [TIME_W-1:0] turnaround,
	output logic [TIME_W-1:0] tick_time
);

	`include "shortest_remaining_time_scheduler_defines.svh"

	job_entry_t mem [MAX_JOBS];

	state_t            state_q, state_nxt;
	logic [CNT_W-1:0]  job_count_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic [IDX_W-1:0]  last_idx;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	job_entry_t        rd_data_s1;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	job_entry_t        best_q;
	logic              take;

	logic              req_acc, rsp_load;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	job_entry_t        mem_wdata;
	logic              full;

	logic [TIME_W-1:0] since, new_rem, turn;

	status_t           res_status_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_first_q, res_fin_q;
	logic [TIME_W-1:0] res_wait_q, res_turn_q, res_tick_q;

	logic              rsp_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        job_index_q;
	logic              first_run_q, finished_q;
	logic [TIME_W-1:0] first_wait_q, turnaround_q, tick_time_q;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign full      = (job_count_q == CNT_W'(MAX_JOBS));
	assign last_idx  = IDX_W'(job_count_q - CNT_W'(1));

	assign take = rd_v_s1 && (rd_data_s1.ready <= now_q) && (rd_data_s1.rem != '0)
		&& (!found_q || (rd_data_s1.rem < best_q.rem));

	assign since   = now_q - best_q.ready;
	assign new_rem = best_q.rem - TIME_W'(1);
	assign turn    = (since == TIME_MAX) ? TIME_MAX : since + TIME_W'(1);

	always_comb begin
		state_nxt = state_q;
		mem_we    = 1'b0;
		mem_waddr = job_count_q[IDX_W-1:0];
		mem_wdata = '{started: 1'b0, ready: arrival_time, rem: burst_length};
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (opcode)
						OP_CLEAR: state_nxt = ST_RESULT;
						OP_ADD: begin
							state_nxt = ST_RESULT;
							mem_we    = !full;
						end
						OP_TICK: state_nxt = (job_count_q == '0) ? ST_UPDATE : ST_SCAN;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (rd_addr_q == last_idx) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nxt = ST_UPDATE;
			ST_UPDATE: begin
				state_nxt = ST_RESULT;
				mem_we    = found_q;
				mem_waddr = best_idx_q;
				mem_wdata = '{started: 1'b1, ready: best_q.ready, rem: new_rem};
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// job table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_addr_q];
		rd_idx_s1  <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
			now_q       <= '0;
			rd_addr_q   <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN);
			if (req_acc) begin
				rd_addr_q <= '0;
				found_q   <= 1'b0;
				if (opcode == OP_CLEAR) begin
					job_count_q <= '0;
					now_q       <= '0;
				end else if (opcode == OP_ADD && !full) begin
					job_count_q <= job_count_q + CNT_W'(1);
				end
			end
			if (state_q == ST_SCAN) begin
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_UPDATE && now_q != TIME_MAX) begin
				now_q <= now_q + TIME_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// best candidate and pending response
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_data_s1;
		end
		if (req_acc) begin
			res_idx_q   <= (opcode == OP_ADD && !full) ? job_count_q[IDX_W-1:0] : '0;
			res_first_q <= 1'b0;
			res_fin_q   <= 1'b0;
			res_wait_q  <= '0;
			res_turn_q  <= '0;
			res_tick_q  <= (opcode == OP_CLEAR) ? '0 : now_q;
			case (opcode)
				OP_CLEAR: res_status_q <= STS_CLEARED;
				OP_ADD:   res_status_q <= full ? STS_FULL : STS_ADDED;
				default:  res_status_q <= STS_IDLE;
			endcase
		end
		if (state_q == ST_UPDATE) begin
			res_tick_q <= now_q;
			if (found_q) begin
				res_status_q <= STS_RAN;
				res_idx_q    <= best_idx_q;
				res_first_q  <= !best_q.started;
				res_wait_q   <= best_q.started ? '0 : since;
				res_fin_q    <= (new_rem == '0);
				res_turn_q   <= (new_rem == '0) ? turn : '0;
			end else begin
				res_status_q <= STS_IDLE;
				res_idx_q    <= '0;
				res_first_q  <= 1'b0;
				res_wait_q   <= '0;
				res_fin_q    <= 1'b0;
				res_turn_q   <= '0;
			end
		end
		if (rsp_load) begin
			status_q     <= res_status_q;
			job_index_q  <= 8'(res_idx_q);
			first_run_q  <= res_first_q;
			finished_q   <= res_fin_q;
			first_wait_q <= res_wait_q;
			turnaround_q <= res_turn_q;
			tick_time_q  <= res_tick_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign job_index  = job_index_q;
	assign first_run  = first_run_q;
	assign finished   = finished_q;
	assign first_wait = first_wait_q;
	assign turnaround = turnaround_q;
	assign tick_time  = tick_time_q;

	`SRT_ASSERT_NOW(a_count_bound, 1'b1, job_count_q <= CNT_W'(MAX_JOBS), "job count overflow")
	`SRT_ASSERT_NOW(a_best_live, found_q && state_q == ST_UPDATE, best_q.rem != '0,
		"picked job has no work")
	`SRT_ASSERT_NEXT(a_tick_scan, req_acc && opcode == OP_TICK && job_count_q != '0,
		state_q == ST_SCAN && rd_addr_q == '0, "tick did not start scan at entry zero")
	`SRT_ASSERT_NEXT(a_rsp_load, rsp_load, rsp_valid_q && state_q == ST_IDLE,
		"response not presented after load")

endmodule
